[rtl/cursor_text_buffer_unit_defines.svh]
// ----------------------------------------------------------------------------
// Cursor text buffer: assertion macros
// Shared concurrent assertion forms, clocked on clk_i and held off in reset.
// ----------------------------------------------------------------------------
`ifndef CURSOR_TEXT_BUFFER_UNIT_DEFINES_SVH
`define CURSOR_TEXT_BUFFER_UNIT_DEFINES_SVH

// Same-cycle implication.
`define CTB_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define CTB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/ctb_pkg.sv]
// ----------------------------------------------------------------------------
// Cursor text buffer package
// Payload structs, command and status codes, control types.
// ----------------------------------------------------------------------------
package ctb_pkg;

  localparam int unsigned OP_W     = 3;
  localparam int unsigned CHAR_W   = 8;
  localparam int unsigned IDX_W    = 12;
  localparam int unsigned LEN_W    = 13;
  localparam int unsigned STATUS_W = 2;

  // Command codes
  localparam logic [OP_W-1:0] OP_LEFT   = 3'd0;
  localparam logic [OP_W-1:0] OP_RIGHT  = 3'd1;
  localparam logic [OP_W-1:0] OP_BKSP   = 3'd2;
  localparam logic [OP_W-1:0] OP_INSERT = 3'd3;
  localparam logic [OP_W-1:0] OP_READ   = 3'd4;

  // Status codes
  localparam logic [STATUS_W-1:0] STAT_DONE     = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_BOUNDARY = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_FULL     = 2'd2;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [CHAR_W-1:0] char_in;
    logic [IDX_W-1:0]  read_index;
  } in_t;

  typedef struct packed {
    logic [CHAR_W-1:0]   read_char;
    logic [LEN_W-1:0]    text_length;
    logic [LEN_W-1:0]    cursor_pos;
    logic [STATUS_W-1:0] status;
  } out_t;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_e;

  // Work decided at command transfer, carried out at commit in the execute state
  typedef enum logic [2:0] {
    ACT_NONE,
    ACT_MOVE_L,
    ACT_MOVE_R,
    ACT_BKSP,
    ACT_INSERT,
    ACT_READ_L,
    ACT_READ_R
  } action_e;

  // Per-cycle control of one stack cell
  typedef struct packed {
    logic rd_en;
    logic push;
    logic pop;
    logic from_nbr;
  } cell_ctrl_t;

endpackage

[rtl/cursor_text_buffer_unit.sv]
// ----------------------------------------------------------------------------
// Cursor text buffer unit
// Result: registered at commit in the execute state after the command transfer
// when the result slot is free; a held result stalls the next command in its
// execute cycle. A new command is taken only in the idle state; a registered
// RAM read precedes each move and read-out. Reset empties both stacks at once.
// ----------------------------------------------------------------------------
`include "cursor_text_buffer_unit_defines.svh"

module cursor_text_buffer_unit #(
  parameter int unsigned CAPACITY = 4096
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  ctb_pkg::in_t   in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output ctb_pkg::out_t  out_data_o
);
  import ctb_pkg::*;

  localparam int unsigned AW    = $clog2(CAPACITY);
  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  // Wide enough for counts, the index and their sum without wrap
  localparam int unsigned XW    = ((CNT_W > IDX_W) ? CNT_W : IDX_W) + 1;

  // Two cells in a row: left of the cursor and right of the cursor.
  // A cursor move pops one cell and pushes its neighbour with the popped byte.
  cell_ctrl_t       l_ctrl, r_ctrl;
  logic [AW-1:0]    l_rd_addr, r_rd_addr;
  logic [CHAR_W-1:0] l_rd_data, r_rd_data;
  logic [CNT_W-1:0] l_count, r_count;

  state_e  state_q, state_d;
  action_e act_q, act_d;
  logic [STATUS_W-1:0] status_q, status_d;
  logic [CHAR_W-1:0]   char_q;

  logic accept, commit;
  logic out_valid_q;
  out_t out_data_q;

  logic [XW-1:0] l_x, r_x, idx_x, cap_x, rel_x, k_x, sum_x;
  logic [XW-1:0] l_after, r_after;
  logic l_need_rd, r_need_rd;

  function automatic logic [LEN_W-1:0] sum_after_w(input logic [XW-1:0] a,
                                                   input logic [XW-1:0] b);
    logic [XW-1:0] s;
    s = a + b;
    return s[LEN_W-1:0];
  endfunction

  assign l_x   = XW'(l_count);
  assign r_x   = XW'(r_count);
  assign idx_x = XW'(in_data_i.read_index);
  assign cap_x = XW'(CAPACITY);
  assign sum_x = l_x + r_x;
  assign rel_x = idx_x - l_x;
  // Right stack keeps the character next to the cursor on top
  assign k_x   = r_x - XW'(1) - rel_x;

  // --------------------------------------------------------------------------
  // Decode: decide the work and the status from the counts at transfer
  // --------------------------------------------------------------------------
  always_comb begin
    act_d     = ACT_NONE;
    status_d  = STAT_DONE;
    l_need_rd = 1'b0;
    r_need_rd = 1'b0;
    l_rd_addr = '0;
    r_rd_addr = '0;
    case (in_data_i.op)
      OP_LEFT: begin
        if (l_x == '0 || r_x >= cap_x) begin
          status_d = STAT_BOUNDARY;
        end else begin
          act_d     = ACT_MOVE_L;
          l_need_rd = 1'b1;
          l_rd_addr = AW'(l_x - XW'(1));
        end
      end
      OP_RIGHT: begin
        if (r_x == '0 || l_x >= cap_x) begin
          status_d = STAT_BOUNDARY;
        end else begin
          act_d     = ACT_MOVE_R;
          r_need_rd = 1'b1;
          r_rd_addr = AW'(r_x - XW'(1));
        end
      end
      OP_BKSP: begin
        if (l_x == '0) begin
          status_d = STAT_BOUNDARY;
        end else begin
          act_d = ACT_BKSP;
        end
      end
      OP_INSERT: begin
        if (sum_x >= cap_x || l_x >= cap_x) begin
          status_d = STAT_FULL;
        end else begin
          act_d = ACT_INSERT;
        end
      end
      OP_READ: begin
        if (idx_x < l_x) begin
          act_d     = ACT_READ_L;
          l_need_rd = 1'b1;
          l_rd_addr = idx_x[AW-1:0];
        end else if (rel_x < r_x) begin
          act_d     = ACT_READ_R;
          r_need_rd = 1'b1;
          r_rd_addr = k_x[AW-1:0];
        end else begin
          status_d = STAT_FULL;
        end
      end
      default: begin
        // Unused codes: no change, done
        act_d = ACT_NONE;
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Sequencer: next state
  // --------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (!out_valid_q || out_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Sequencer: outputs and cell control
  // --------------------------------------------------------------------------
  always_comb begin
    in_ready_o = 1'b0;
    commit     = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
      end
      ST_EXEC: begin
        // Hold the read data and the counts until the result slot is free
        commit = !out_valid_q || out_ready_i;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

  assign accept = in_valid_i && in_ready_o;

  always_comb begin
    l_ctrl          = '0;
    r_ctrl          = '0;
    l_ctrl.rd_en    = accept && l_need_rd;
    r_ctrl.rd_en    = accept && r_need_rd;
    l_ctrl.pop      = commit && (act_q == ACT_MOVE_L || act_q == ACT_BKSP);
    l_ctrl.push     = commit && (act_q == ACT_MOVE_R || act_q == ACT_INSERT);
    l_ctrl.from_nbr = (act_q == ACT_MOVE_R);
    r_ctrl.pop      = commit && (act_q == ACT_MOVE_R);
    r_ctrl.push     = commit && (act_q == ACT_MOVE_L);
    r_ctrl.from_nbr = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Command context: captured at transfer, no reset needed
  always_ff @(posedge clk_i) begin
    if (accept) begin
      act_q    <= act_d;
      status_q <= status_d;
      char_q   <= in_data_i.char_in;
    end
  end

  // --------------------------------------------------------------------------
  // Stack cells
  // --------------------------------------------------------------------------
  ctb_stack_cell #(
    .DEPTH (CAPACITY)
  ) u_left_cell (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (l_ctrl),
    .rd_addr_i  (l_rd_addr),
    .char_i     (char_q),
    .nbr_data_i (r_rd_data),
    .rd_data_o  (l_rd_data),
    .count_o    (l_count)
  );

  ctb_stack_cell #(
    .DEPTH (CAPACITY)
  ) u_right_cell (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (r_ctrl),
    .rd_addr_i  (r_rd_addr),
    .char_i     (char_q),
    .nbr_data_i (l_rd_data),
    .rd_data_o  (r_rd_data),
    .count_o    (r_count)
  );

  // --------------------------------------------------------------------------
  // Result register: counts as they stand after this command
  // --------------------------------------------------------------------------
  assign l_after = l_x + XW'(l_ctrl.push) - XW'(l_ctrl.pop);
  assign r_after = r_x + XW'(r_ctrl.push) - XW'(r_ctrl.pop);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (commit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit) begin
      out_data_q.text_length <= sum_after_w(l_after, r_after);
      out_data_q.cursor_pos  <= l_after[LEN_W-1:0];
      out_data_q.status      <= status_q;
      case (act_q)
        ACT_READ_L: out_data_q.read_char <= l_rd_data;
        ACT_READ_R: out_data_q.read_char <= r_rd_data;
        default:    out_data_q.read_char <= '0;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `CTB_ASSERT_NOW(a_total_in_range, 1'b1, sum_x <= cap_x, "text exceeds capacity")
  `CTB_ASSERT_NEXT(a_commit_gives_result, commit, out_valid_o, "commit without result")
  `CTB_ASSERT_NEXT(a_counts_hold, !commit,
                   $stable(l_count) && $stable(r_count), "counts moved without commit")
  `CTB_ASSERT_NEXT(a_move_left, commit && act_q == ACT_MOVE_L,
                   (l_count == $past(l_count) - CNT_W'(1)) &&
                   (r_count == $past(r_count) + CNT_W'(1)), "left move lost a byte")

endmodule

[rtl/ctb_ram.sv]
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module ctb_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/ctb_stack_cell.sv]
// ----------------------------------------------------------------------------
// Stack cell
// One side of the gap: a byte stack in RAM with its fill count. Popped data
// leaves on rd_data_o towards the neighbouring cell; pushes take either the
// neighbour's data or a fresh character.
// ----------------------------------------------------------------------------
module ctb_stack_cell #(
  parameter int unsigned DEPTH = 4096
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  ctb_pkg::cell_ctrl_t                 ctrl_i,
  input  logic [$clog2(DEPTH)-1:0]            rd_addr_i,
  input  logic [ctb_pkg::CHAR_W-1:0]          char_i,
  input  logic [ctb_pkg::CHAR_W-1:0]          nbr_data_i,
  output logic [ctb_pkg::CHAR_W-1:0]          rd_data_o,
  output logic [$clog2(DEPTH+1)-1:0]          count_o
);
  import ctb_pkg::*;

  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [CNT_W-1:0]  count_q, count_d;
  logic [CHAR_W-1:0] wdata;

  // Push lands on top, pop drops the top; never both in one cycle
  always_comb begin
    count_d = count_q;
    if (ctrl_i.push) begin
      count_d = count_q + CNT_W'(1);
    end else if (ctrl_i.pop) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  assign wdata = ctrl_i.from_nbr ? nbr_data_i : char_i;

  ctb_ram #(
    .WIDTH (CHAR_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ctrl_i.push),
    .waddr_i (count_q[AW-1:0]),
    .wdata_i (wdata),
    .re_i    (ctrl_i.rd_en),
    .raddr_i (rd_addr_i),
    .rdata_o (rd_data_o)
  );

  assign count_o = count_q;

endmodule

[verif/tb_top.sv]
// ----------------------------------------------------------------------------
// Cursor text buffer unit testbench
// Drives edit commands (cursor moves, backspace, insert, read) through the
// valid/ready command channel and checks every result transfer against a
// typed result or a gap-buffer predictor. Directed rows cover the boundaries,
// reads out of range and unused command codes; a random edit session follows.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import ctb_pkg::*;

  localparam int unsigned CAPACITY    = 4096;
  localparam int unsigned EDIT_ITEMS  = 1180;
  localparam int unsigned IDLE_PCT    = 8;
  localparam int unsigned DRAIN_TICKS = 10;
  localparam int unsigned EXP_DEPTH   = 64;

  // Command codes the block leaves unused
  localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd5;
  localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;

  logic clk_i       = 1'b0;
  logic rst_ni      = 1'b0;
  logic in_valid_i  = 1'b0;
  logic out_ready_i = 1'b0;
  in_t  in_data_i   = '0;
  logic in_ready_o;
  logic out_valid_o;
  out_t out_data_o;

  // One row of the directed table: a command, how often to repeat it, whether
  // to draw a fresh random byte per repeat, and an optional typed result
  typedef struct packed {
    in_t         cmd;
    int unsigned reps;
    bit          rand_char;
    bit          typed;
    out_t        result;
  } stim_row_t;

  localparam int unsigned N_ROWS = 18;

  stim_row_t directed_rows [N_ROWS] = '{
    // empty buffer: every move, delete and read is refused
    '{'{OP_LEFT,   8'h00, 12'd0},    1, 1'b0, 1'b1, '{8'h00, 13'd0, 13'd0, STAT_BOUNDARY}},
    '{'{OP_RIGHT,  8'h00, 12'd0},    1, 1'b0, 1'b1, '{8'h00, 13'd0, 13'd0, STAT_BOUNDARY}},
    '{'{OP_BKSP,   8'h00, 12'd0},    1, 1'b0, 1'b1, '{8'h00, 13'd0, 13'd0, STAT_BOUNDARY}},
    '{'{OP_READ,   8'h00, 12'd0},    1, 1'b0, 1'b1, '{8'h00, 13'd0, 13'd0, STAT_FULL}},
    '{'{OP_READ,   8'hFF, 12'd4095}, 1, 1'b0, 1'b1, '{8'h00, 13'd0, 13'd0, STAT_FULL}},
    '{'{OP_SPARE_LO, 8'hFF, 12'd4095}, 1, 1'b0, 1'b1, '{8'h00, 13'd0, 13'd0, STAT_DONE}},
    '{'{OP_SPARE_HI, 8'hFF, 12'd4095}, 1, 1'b0, 1'b1, '{8'h00, 13'd0, 13'd0, STAT_DONE}},
    // short text: extreme bytes, reads from both sides of the cursor
    '{'{OP_INSERT, 8'h00, 12'd0},    1, 1'b0, 1'b1, '{8'h00, 13'd1, 13'd1, STAT_DONE}},
    '{'{OP_INSERT, 8'hFF, 12'd0},    1, 1'b0, 1'b1, '{8'h00, 13'd2, 13'd2, STAT_DONE}},
    '{'{OP_READ,   8'h00, 12'd0},    1, 1'b0, 1'b1, '{8'h00, 13'd2, 13'd2, STAT_DONE}},
    '{'{OP_READ,   8'h00, 12'd1},    1, 1'b0, 1'b1, '{8'hFF, 13'd2, 13'd2, STAT_DONE}},
    '{'{OP_LEFT,   8'h00, 12'd0},    1, 1'b0, 1'b1, '{8'h00, 13'd2, 13'd1, STAT_DONE}},
    '{'{OP_READ,   8'h00, 12'd1},    1, 1'b0, 1'b1, '{8'hFF, 13'd2, 13'd1, STAT_DONE}},
    '{'{OP_INSERT, 8'hA5, 12'd0},    1, 1'b0, 1'b1, '{8'h00, 13'd3, 13'd2, STAT_DONE}},
    '{'{OP_READ,   8'h00, 12'd2},    1, 1'b0, 1'b1, '{8'hFF, 13'd3, 13'd2, STAT_DONE}},
    '{'{OP_RIGHT,  8'h00, 12'd0},    1, 1'b0, 1'b1, '{8'h00, 13'd3, 13'd3, STAT_DONE}},
    '{'{OP_RIGHT,  8'h00, 12'd0},    1, 1'b0, 1'b1, '{8'h00, 13'd3, 13'd3, STAT_BOUNDARY}},
    '{'{OP_BKSP,   8'h00, 12'd0},    1, 1'b0, 1'b1, '{8'h00, 13'd2, 13'd2, STAT_DONE}}
  };

  // Gap-buffer copy of the text, and results still owed by the block
  logic [CHAR_W-1:0] left_chars  [CAPACITY];
  logic [CHAR_W-1:0] right_chars [CAPACITY];
  int unsigned       left_len  = 0;
  int unsigned       right_len = 0;
  out_t              exp_fifo [EXP_DEPTH];
  int unsigned       exp_wr  = 0;
  int unsigned       exp_rd  = 0;
  int unsigned       err_cnt = 0;

  cursor_text_buffer_unit #(
    .CAPACITY (CAPACITY)
  ) uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  always #5 clk_i = ~clk_i;

  // Apply one edit command to the text copy and return the result it owes
  function automatic out_t apply_edit(in_t cmd);
    out_t        res;
    int unsigned idx;
    res = '0;
    res.status = STAT_DONE;
    idx = {20'd0, cmd.read_index};
    case (cmd.op)
      OP_LEFT: begin
        if (left_len == 0 || right_len >= CAPACITY) begin
          res.status = STAT_BOUNDARY;
        end else begin
          left_len--;
          right_chars[right_len] = left_chars[left_len];
          right_len++;
        end
      end
      OP_RIGHT: begin
        if (right_len == 0 || left_len >= CAPACITY) begin
          res.status = STAT_BOUNDARY;
        end else begin
          right_len--;
          left_chars[left_len] = right_chars[right_len];
          left_len++;
        end
      end
      OP_BKSP: begin
        if (left_len == 0) begin
          res.status = STAT_BOUNDARY;
        end else begin
          left_len--;
        end
      end
      OP_INSERT: begin
        if (left_len + right_len >= CAPACITY) begin
          res.status = STAT_FULL;
        end else begin
          left_chars[left_len] = cmd.char_in;
          left_len++;
        end
      end
      OP_READ: begin
        // right stack top sits just right of the cursor
        if (idx < left_len) begin
          res.read_char = left_chars[idx];
        end else if (idx - left_len < right_len) begin
          res.read_char = right_chars[right_len - 1 - (idx - left_len)];
        end else begin
          res.status = STAT_FULL;
        end
      end
      default: begin
      end
    endcase
    res.text_length = LEN_W'(left_len + right_len);
    res.cursor_pos  = LEN_W'(left_len);
    return res;
  endfunction

  task automatic check_field(input string field, input int unsigned exp_v,
                             input int unsigned got_v);
    if (exp_v != got_v) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, exp_v, got_v);
      err_cnt++;
    end
  endtask

  // Offer one command, idling at random first unless calm; hold valid until the transfer
  task automatic send_cmd(input in_t cmd, input bit calm, input bit typed,
                          input out_t typed_res);
    out_t predicted;
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= cmd;
    do @(posedge clk_i); while (!in_ready_o);
    predicted = apply_edit(cmd);
    exp_fifo[exp_wr % EXP_DEPTH] = typed ? typed_res : predicted;
    exp_wr++;
  endtask

  // Result side: check each transfer, then decide ready for the next cycle
  initial begin : result_sink
    out_t        exp_res;
    int unsigned rx_count;
    int unsigned hold_cnt;
    bit          held_once;
    rx_count  = 0;
    hold_cnt  = 0;
    held_once = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && out_ready_i) begin
        rx_count++;
        if (exp_wr == exp_rd) begin
          $display("%0t: unexpected result, expected none, actual %h", $time, out_data_o);
          err_cnt++;
        end else begin
          exp_res = exp_fifo[exp_rd % EXP_DEPTH];
          exp_rd++;
          check_field("read_char",   32'(exp_res.read_char),   32'(out_data_o.read_char));
          check_field("text_length", 32'(exp_res.text_length), 32'(out_data_o.text_length));
          check_field("cursor_pos",  32'(exp_res.cursor_pos),  32'(out_data_o.cursor_pos));
          check_field("status",      32'(exp_res.status),      32'(out_data_o.status));
        end
      end
      // hold off once for a long stretch so the block backs up into its input
      if (!held_once && rx_count == 400) begin
        held_once = 1'b1;
        hold_cnt  = 300;
      end
      if (!rst_ni) begin
        out_ready_i <= 1'b0;
      end else if (hold_cnt > 0) begin
        hold_cnt--;
        out_ready_i <= 1'b0;
      end else if (rx_count >= 650 && rx_count < 850) begin
        out_ready_i <= 1'b1;
      end else begin
        out_ready_i <= ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // Command side: reset, directed table, random edit session, drain
  initial begin : cmd_source
    in_t         cmd;
    int unsigned edits;
    int unsigned pick;
    int unsigned text_len;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int r = 0; r < N_ROWS; r++) begin
      for (int unsigned k = 0; k < directed_rows[r].reps; k++) begin
        cmd = directed_rows[r].cmd;
        if (directed_rows[r].rand_char) begin
          cmd.char_in = CHAR_W'($urandom_range(255));
        end
        send_cmd(cmd, 1'b0, directed_rows[r].typed, directed_rows[r].result);
      end
    end

    // Random session: mostly inserts and reads so the line grows; spare codes
    // are mixed in as noise and do not count as edits
    edits = 0;
    while (edits < EDIT_ITEMS) begin
      pick     = $urandom_range(99);
      text_len = left_len + right_len;
      cmd.char_in    = CHAR_W'($urandom_range(255));
      cmd.read_index = IDX_W'($urandom_range(4095));
      if (pick < 15) begin
        cmd.op = OP_LEFT;
      end else if (pick < 30) begin
        cmd.op = OP_RIGHT;
      end else if (pick < 42) begin
        cmd.op = OP_BKSP;
      end else if (pick < 75) begin
        cmd.op = OP_INSERT;
      end else if (pick < 95) begin
        cmd.op = OP_READ;
        // mostly inside the text or one past its end
        if ($urandom_range(3) != 0) begin
          cmd.read_index = IDX_W'($urandom_range((text_len > 4095) ? 4095 : text_len));
        end
      end else begin
        cmd.op = OP_LEFT + OP_W'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
      end
      if (cmd.op <= OP_READ) begin
        edits++;
      end
      send_cmd(cmd, (edits >= 600 && edits < 800), 1'b0, '0);
    end
    in_valid_i <= 1'b0;

    while (exp_wr != exp_rd) @(posedge clk_i);
    repeat (DRAIN_TICKS) @(posedge clk_i);

    if (err_cnt == 0 && exp_wr == exp_rd) begin
      $display("[cursor_text_buffer_unit] OK");
    end else begin
      $display("[cursor_text_buffer_unit] ERROR");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run
  initial begin : watchdog
    #(5_000_000);
    $display("[cursor_text_buffer_unit] ERROR");
    $finish;
  end

endmodule

[sim.f]
+incdir+rtl
rtl/ctb_pkg.sv
rtl/ctb_ram.sv
rtl/ctb_stack_cell.sv
rtl/cursor_text_buffer_unit.sv
verif/tb_top.sv
